@@ hw/rtl/hhmr_pkg.sv @@
// ---------------------------------------------------------------------------
// hhmr_pkg
// Shared types, constants and the address decoder of the memory map router.
// ---------------------------------------------------------------------------
`default_nettype none

package hhmr_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int HIGH_RAM_BYTES = 128;
    localparam int BYTE_W         = 8;
    localparam int ADDR_W         = 16;
    localparam int WORD_W         = 16;

    typedef enum logic [1:0] {
        OP_READ_BYTE  = 2'd0,
        OP_READ_WORD  = 2'd1,
        OP_WRITE_BYTE = 2'd2,
        OP_WRITE_WORD = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        REGION_ROM    = 4'd0,
        REGION_VRAM   = 4'd1,
        REGION_CRAM   = 4'd2,
        REGION_WRAM   = 4'd3,
        REGION_ECHO   = 4'd4,
        REGION_SPRITE = 4'd5,
        REGION_EMPTY  = 4'd6,
        REGION_IO     = 4'd7,
        REGION_HRAM   = 4'd8,
        REGION_INT    = 4'd9
    } region_t;

    localparam logic [ADDR_W-1:0] BASE_VRAM   = 16'h8000;
    localparam logic [ADDR_W-1:0] BASE_CRAM   = 16'hA000;
    localparam logic [ADDR_W-1:0] BASE_WRAM   = 16'hC000;
    localparam logic [ADDR_W-1:0] BASE_ECHO   = 16'hE000;
    localparam logic [ADDR_W-1:0] BASE_SPRITE = 16'hFE00;
    localparam logic [ADDR_W-1:0] BASE_EMPTY  = 16'hFEA0;
    localparam logic [ADDR_W-1:0] BASE_IO     = 16'hFF00;
    localparam logic [ADDR_W-1:0] BASE_HRAM   = 16'hFF80;
    localparam logic [ADDR_W-1:0] BASE_INT    = 16'hFFFF;

    // Bus access as seen on the control side of one memory bank pair
    typedef struct packed {
        logic              en;
        logic              we;
        logic              word;
    } bank_ctrl_t;

    function automatic region_t decode_region(input logic [ADDR_W-1:0] a);
        region_t r;
        if (a < BASE_VRAM)        r = REGION_ROM;
        else if (a < BASE_CRAM)   r = REGION_VRAM;
        else if (a < BASE_WRAM)   r = REGION_CRAM;
        else if (a < BASE_ECHO)   r = REGION_WRAM;
        else if (a < BASE_SPRITE) r = REGION_ECHO;
        else if (a < BASE_EMPTY)  r = REGION_SPRITE;
        else if (a < BASE_IO)     r = REGION_EMPTY;
        else if (a < BASE_HRAM)   r = REGION_IO;
        else if (a < BASE_INT)    r = REGION_HRAM;
        else                      r = REGION_INT;
        return r;
    endfunction

    // Cartridge regions report the full address
    function automatic logic [ADDR_W-1:0] region_base(input region_t r);
        logic [ADDR_W-1:0] b;
        case (r)
            REGION_VRAM:   b = BASE_VRAM;
            REGION_WRAM:   b = BASE_WRAM;
            REGION_ECHO:   b = BASE_ECHO;
            REGION_SPRITE: b = BASE_SPRITE;
            REGION_EMPTY:  b = BASE_EMPTY;
            REGION_IO:     b = BASE_IO;
            REGION_HRAM:   b = BASE_HRAM;
            REGION_INT:    b = BASE_INT;
            default:       b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hhmr_bank.sv @@
// ---------------------------------------------------------------------------
// hhmr_bank
// Byte store split into even and odd banks so that a little-endian word
// access touches each bank once; the second byte wraps inside the store.
// ---------------------------------------------------------------------------
`default_nettype none

module hhmr_bank
    import hhmr_pkg::*;
#(
    parameter int DEPTH = WORK_RAM_BYTES
) (
    input  wire logic                      clk,
    input  wire bank_ctrl_t                ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]  offset,
    input  wire logic [WORD_W-1:0]         wdata,
    output logic      [WORD_W-1:0]         rdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int HALF = DEPTH / 2;

    logic [BYTE_W-1:0] mem_even_reg [HALF];
    logic [BYTE_W-1:0] mem_odd_reg  [HALF];
    logic [BYTE_W-1:0] even_q_reg;
    logic [BYTE_W-1:0] odd_q_reg;
    logic              swap_reg;

    logic [AW-1:0]     next_off;
    logic [AW-2:0]     even_addr;
    logic [AW-2:0]     odd_addr;
    logic              odd;
    logic              even_we;
    logic              odd_we;
    logic [BYTE_W-1:0] even_wdata;
    logic [BYTE_W-1:0] odd_wdata;

    always_comb
    begin
        odd        = offset[0];
        next_off   = offset + AW'(1);
        // an even offset never carries out of bit 0, so both byte orders share this
        even_addr  = next_off[AW-1:1];
        odd_addr   = offset[AW-1:1];
        even_we    = ctrl.en && ctrl.we && (!odd || ctrl.word);
        odd_we     = ctrl.en && ctrl.we && (odd || ctrl.word);
        even_wdata = odd ? wdata[WORD_W-1:BYTE_W] : wdata[BYTE_W-1:0];
        odd_wdata  = odd ? wdata[BYTE_W-1:0] : wdata[WORD_W-1:BYTE_W];
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            mem_even_reg[even_addr] <= even_wdata;
        end
        if (odd_we)
        begin
            mem_odd_reg[odd_addr] <= odd_wdata;
        end
        if (ctrl.en)
        begin
            even_q_reg <= mem_even_reg[even_addr];
            odd_q_reg  <= mem_odd_reg[odd_addr];
            swap_reg   <= odd;
        end
    end

    assign rdata = swap_reg ? {even_q_reg, odd_q_reg} : {odd_q_reg, even_q_reg};

endmodule

`default_nettype wire

@@ hw/rtl/handheld_memory_map_router.sv @@
// ---------------------------------------------------------------------------
// handheld_memory_map_router
// Decodes CPU bus accesses and serves working RAM, its echo and high RAM.
// ---------------------------------------------------------------------------
// The router accepts one bus access per clock and presents its result in the
// following cycle, from the registered read of the RAM banks; it stalls only
// while a finished result is not taken. Working RAM and high RAM each sit in
// an even/odd bank pair, so a word access reads or writes both bytes at once.
// Writes land at the accepting edge, so the next access already sees them.
// Cartridge, video, sprite, and byte I/O and interrupt accesses come back
// with forward set, the region and the offset; read_data is zero there, on
// writes and in the empty range. RAM contents are undefined until written.
`default_nettype none

module handheld_memory_map_router
    import hhmr_pkg::*;
#(
    parameter int WORK_RAM_BYTES = hhmr_pkg::WORK_RAM_BYTES,
    parameter int HIGH_RAM_BYTES = hhmr_pkg::HIGH_RAM_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[1:0], address[17:2], write_data[33:18], zero[39:34]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[15:0], region[19:16], forward[20], offset[36:21], zero[39:37]
    output logic      [39:0] m_tdata
);

    localparam int WAW = $clog2(WORK_RAM_BYTES);
    localparam int HAW = $clog2(HIGH_RAM_BYTES);

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_WRAM,
        SRC_HRAM
    } src_t;

    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] write_data;
    region_t           region;
    logic [ADDR_W-1:0] offset;
    logic              word;
    logic              is_write;
    logic              forward;
    logic              accept;
    bank_ctrl_t        wram_ctrl;
    bank_ctrl_t        hram_ctrl;
    logic [WORD_W-1:0] wram_rdata;
    logic [WORD_W-1:0] hram_rdata;
    logic [WORD_W-1:0] src_data;
    logic [WORD_W-1:0] read_data;

    logic              valid_reg;
    logic              valid_next;
    region_t           region_reg;
    logic              forward_reg;
    logic [ADDR_W-1:0] offset_reg;
    src_t              src_reg;
    src_t              src_next;
    logic              word_reg;

    always_comb
    begin
        op         = op_t'(s_tdata[1:0]);
        address    = s_tdata[17:2];
        write_data = s_tdata[33:18];
        word       = (op == OP_READ_WORD) || (op == OP_WRITE_WORD);
        is_write   = (op == OP_WRITE_BYTE) || (op == OP_WRITE_WORD);
        region     = decode_region(address);
        offset     = address - region_base(region);
        accept     = s_tvalid && s_tready;

        case (region)
            REGION_WRAM, REGION_ECHO, REGION_HRAM, REGION_EMPTY: forward = 1'b0;
            REGION_IO, REGION_INT:                              forward = !word;
            default:                                            forward = 1'b1;
        endcase

        wram_ctrl.en   = accept && ((region == REGION_WRAM) || (region == REGION_ECHO));
        wram_ctrl.we   = is_write;
        wram_ctrl.word = word;
        hram_ctrl.en   = accept && (region == REGION_HRAM);
        hram_ctrl.we   = is_write;
        hram_ctrl.word = word;

        src_next = SRC_NONE;
        if (!is_write && wram_ctrl.en)
        begin
            src_next = SRC_WRAM;
        end
        else if (!is_write && hram_ctrl.en)
        begin
            src_next = SRC_HRAM;
        end

        // hold the result while the consumer stalls
        s_tready   = !valid_reg || m_tready;
        valid_next = accept || (valid_reg && !m_tready);
    end

    hhmr_bank #(
        .DEPTH (WORK_RAM_BYTES)
    ) u_wram (
        .clk    (clk),
        .ctrl   (wram_ctrl),
        .offset (address[WAW-1:0]),
        .wdata  (write_data),
        .rdata  (wram_rdata)
    );

    hhmr_bank #(
        .DEPTH (HIGH_RAM_BYTES)
    ) u_hram (
        .clk    (clk),
        .ctrl   (hram_ctrl),
        .offset (address[HAW-1:0]),
        .wdata  (write_data),
        .rdata  (hram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            src_reg   <= SRC_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                src_reg <= src_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            region_reg  <= region;
            forward_reg <= forward;
            offset_reg  <= offset;
            word_reg    <= word;
        end
    end

    always_comb
    begin
        case (src_reg)
            SRC_WRAM: src_data = wram_rdata;
            SRC_HRAM: src_data = hram_rdata;
            default:  src_data = '0;
        endcase
        read_data = word_reg ? src_data : {{(WORD_W-BYTE_W){1'b0}}, src_data[BYTE_W-1:0]};
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, offset_reg, forward_reg, region_reg, read_data};

    a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && forward_reg |-> read_data == '0)
        else $error("forwarded access carries read data");

    a_ram_local: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((region_reg == REGION_WRAM) || (region_reg == REGION_ECHO)
                     || (region_reg == REGION_HRAM)) |-> !forward_reg)
        else $error("internal RAM access forwarded");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted access produced no result");

    a_src_region: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (src_reg == SRC_HRAM) |-> region_reg == REGION_HRAM)
        else $error("high RAM data on a non high RAM result");

endmodule

`default_nettype wire

@@ sim/handheld_memory_map_router_tb.sv @@
// ---------------------------------------------------------------------------
// handheld_memory_map_router_tb
// Self-checking bench for the memory map router. A queue of bus accesses
// feeds a stream driver. A behavioral router with its own RAM images
// predicts each result, and the monitor compares results field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module handheld_memory_map_router_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hhmr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 475;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        op_t         op;
        logic [15:0] addr;
        logic [15:0] data;
    } access_t;

    typedef struct {
        logic [15:0] rd;
        region_t     region;
        logic        fwd;
        logic [15:0] off;
    } route_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    access_t       bus_accesses[$];
    route_result_t due_results[$];
    access_t       in_flight;
    bit            in_taken;

    // Written-byte maps: reads are steered only onto bytes already stored
    bit wram_known[WORK_RAM_BYTES];
    bit hram_known[HIGH_RAM_BYTES];

    // RAM images of the behavioral router
    logic [7:0] wram_image[WORK_RAM_BYTES];
    logic [7:0] hram_image[HIGH_RAM_BYTES];

    int idle_pct;
    int stall_pct;
    int cycle_count;
    int mismatches;
    int checked;
    int ram_reads;
    int forwarded;
    int wrapped_words;
    int phase;
    logic [12:0] hot_base;

    handheld_memory_map_router i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic route_result_t route_access(input access_t a);
        route_result_t r;
        logic [15:0]   base;
        logic          word;
        logic [12:0]   w0;
        logic [12:0]   w1;
        logic [6:0]    h0;
        logic [6:0]    h1;
        word = a.op[0];
        r.rd = '0;
        r.fwd = 1'b0;
        if (a.addr < BASE_VRAM)
        begin
            r.region = REGION_ROM;
            base = '0;
        end
        else if (a.addr < BASE_CRAM)
        begin
            r.region = REGION_VRAM;
            base = BASE_VRAM;
        end
        else if (a.addr < BASE_WRAM)
        begin
            r.region = REGION_CRAM;
            base = '0;
        end
        else if (a.addr < BASE_ECHO)
        begin
            r.region = REGION_WRAM;
            base = BASE_WRAM;
        end
        else if (a.addr < BASE_SPRITE)
        begin
            r.region = REGION_ECHO;
            base = BASE_ECHO;
        end
        else if (a.addr < BASE_EMPTY)
        begin
            r.region = REGION_SPRITE;
            base = BASE_SPRITE;
        end
        else if (a.addr < BASE_IO)
        begin
            r.region = REGION_EMPTY;
            base = BASE_EMPTY;
        end
        else if (a.addr < BASE_HRAM)
        begin
            r.region = REGION_IO;
            base = BASE_IO;
        end
        else if (a.addr < BASE_INT)
        begin
            r.region = REGION_HRAM;
            base = BASE_HRAM;
        end
        else
        begin
            r.region = REGION_INT;
            base = BASE_INT;
        end
        r.off = a.addr - base;

        case (r.region)
            REGION_WRAM, REGION_ECHO:
            begin
                // Second byte wraps inside the 8 KiB store
                w0 = r.off[12:0];
                w1 = w0 + 13'd1;
                if (word && w1 == '0)
                    wrapped_words++;
                case (a.op)
                    OP_READ_BYTE:  r.rd = {8'h00, wram_image[w0]};
                    OP_READ_WORD:  r.rd = {wram_image[w1], wram_image[w0]};
                    OP_WRITE_BYTE: wram_image[w0] = a.data[7:0];
                    OP_WRITE_WORD:
                    begin
                        wram_image[w0] = a.data[7:0];
                        wram_image[w1] = a.data[15:8];
                    end
                endcase
                if (!a.op[1])
                    ram_reads++;
            end
            REGION_HRAM:
            begin
                h0 = r.off[6:0];
                h1 = h0 + 7'd1;
                case (a.op)
                    OP_READ_BYTE:  r.rd = {8'h00, hram_image[h0]};
                    OP_READ_WORD:  r.rd = {hram_image[h1], hram_image[h0]};
                    OP_WRITE_BYTE: hram_image[h0] = a.data[7:0];
                    OP_WRITE_WORD:
                    begin
                        hram_image[h0] = a.data[7:0];
                        hram_image[h1] = a.data[15:8];
                    end
                endcase
                if (!a.op[1])
                    ram_reads++;
            end
            REGION_EMPTY:
                ;
            // Word access to I/O or the interrupt register is absorbed here
            REGION_IO, REGION_INT:
                r.fwd = !word;
            default:
                r.fwd = 1'b1;
        endcase
        if (r.fwd)
            forwarded++;
        return r;
    endfunction

    // Queue one access, turning a read of never-written RAM into a write of the same size
    function automatic void queue_access(input op_t op, input logic [15:0] addr,
                                         input logic [15:0] data);
        access_t     a;
        logic [12:0] w0;
        logic [12:0] w1;
        logic [6:0]  h0;
        logic [6:0]  h1;
        logic        word;
        logic        in_wram;
        logic        in_hram;
        word = op[0];
        w0 = addr[12:0];
        w1 = w0 + 13'd1;
        h0 = addr[6:0];
        h1 = h0 + 7'd1;
        in_wram = addr >= BASE_WRAM && addr < BASE_SPRITE;
        in_hram = addr >= BASE_HRAM && addr < BASE_INT;
        if (!op[1])
        begin
            if ((in_wram && !(wram_known[w0] && (!word || wram_known[w1]))) ||
                (in_hram && !(hram_known[h0] && (!word || hram_known[h1]))))
                op = word ? OP_WRITE_WORD : OP_WRITE_BYTE;
        end
        if (op[1] && in_wram)
        begin
            wram_known[w0] = 1'b1;
            if (word)
                wram_known[w1] = 1'b1;
        end
        if (op[1] && in_hram)
        begin
            hram_known[h0] = 1'b1;
            if (word)
                hram_known[h1] = 1'b1;
        end
        a.op = op;
        a.addr = addr;
        a.data = data;
        bus_accesses.push_back(a);
    endfunction

    function automatic logic [15:0] pick_address();
        int          roll;
        logic [12:0] idx;
        logic [15:0] addr;
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            // Hot window of working RAM, reached through both aliases
            idx = hot_base + 13'($urandom_range(0, 47));
            if (idx < 13'h1E00 && $urandom_range(0, 1) == 1)
                addr = BASE_ECHO | {3'b000, idx};
            else
                addr = BASE_WRAM | {3'b000, idx};
        end
        else if (roll < 40)
        begin
            case ($urandom_range(0, 4))
                0:       addr = 16'hDFFF;
                1:       addr = 16'hDFFE;
                2:       addr = 16'hC000;
                3:       addr = 16'hFDFF;
                default: addr = 16'hE000;
            endcase
        end
        else if (roll < 60)
            addr = BASE_HRAM + 16'($urandom_range(0, 126));
        else if (roll < 75)
            addr = BASE_SPRITE + 16'($urandom_range(0, 511));
        else
            addr = 16'($urandom_range(0, 65535));
        return addr;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: advance to the next access once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (!s_tvalid || in_taken)
            begin
                if (bus_accesses.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_flight = bus_accesses.pop_front();
                    s_tdata  <= {6'd0, in_flight.data, in_flight.addr, in_flight.op};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check the result first, then predict the newly taken access
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transaction with no access outstanding: 0x%0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("read_data", want.rd, m_tdata[15:0]);
                    check_field("region", 16'(want.region), 16'(m_tdata[19:16]));
                    check_field("forward", 16'(want.fwd), 16'(m_tdata[20]));
                    check_field("offset", want.off, m_tdata[36:21]);
                    checked++;
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken)
                due_results.push_back(route_access(in_flight));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        idle_pct = 0;
        stall_pct = 0;
        in_taken = 1'b0;

        // Directed: byte write keeps low byte, word wrap at the store end,
        // echo aliasing, high RAM ends, empty range, word I/O and interrupt
        // absorbed, byte I/O and interrupt forwarded, cartridge regions.
        queue_access(OP_WRITE_BYTE, 16'hC000, 16'h1234);
        queue_access(OP_READ_BYTE,  16'hC000, 16'hFFFF);
        queue_access(OP_WRITE_WORD, 16'hDFFF, 16'hA55A);
        queue_access(OP_READ_WORD,  16'hDFFF, 16'h0000);
        queue_access(OP_READ_BYTE,  16'hE000, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFDFF, 16'hFFFF);
        queue_access(OP_READ_WORD,  16'hDDFF, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFF80, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFFFE, 16'hBEEF);
        queue_access(OP_READ_WORD,  16'hFFFE, 16'h0000);
        queue_access(OP_READ_WORD,  16'hFEA0, 16'h0000);
        queue_access(OP_WRITE_BYTE, 16'hFEFF, 16'h00FF);
        queue_access(OP_READ_BYTE,  16'hFF00, 16'h0000);
        queue_access(OP_READ_WORD,  16'hFF7F, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFF40, 16'h1234);
        queue_access(OP_WRITE_BYTE, 16'hFF7F, 16'h005A);
        queue_access(OP_READ_BYTE,  16'hFFFF, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFFFF, 16'hCAFE);
        queue_access(OP_READ_WORD,  16'h0000, 16'h0000);
        queue_access(OP_WRITE_BYTE, 16'h7FFF, 16'h0077);
        queue_access(OP_READ_BYTE,  16'h8000, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hBFFF, 16'h1111);
        queue_access(OP_READ_BYTE,  16'hFE00, 16'h0000);
        queue_access(OP_WRITE_WORD, 16'hFE9F, 16'h2222);

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    idle_pct = 29;
                    stall_pct = 29;
                end
            endcase
            hot_base = 13'($urandom_range(0, WORK_RAM_BYTES - 1));
            repeat (PHASE_ITEMS)
                queue_access(op_t'($urandom_range(0, 3)), pick_address(),
                             16'($urandom_range(0, 65535)));
            while (bus_accesses.size() != 0 || s_tvalid || due_results.size() != 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d accesses checked over four flow-control phases", checked);
        $display("RAM reads %0d, forwarded %0d, wrapping word accesses %0d",
                 ram_reads, forwarded, wrapped_words);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
